[rtl/dog_box_blur_threshold_top_assert.svh]
// Assertion macros shared by the checker
`ifndef DOG_BOX_BLUR_THRESHOLD_TOP_ASSERT_SVH
`define DOG_BOX_BLUR_THRESHOLD_TOP_ASSERT_SVH

// ante in one cycle implies cons in the next, ignored while in reset
`define DBBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dbbt checker: next-cycle property failed");

// same, also checked across reset
`define DBBT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dbbt checker: property failed");

`endif

[rtl/dbbt_pkg.sv]
package dbbt_pkg;

   localparam int DEF_MAX_LINE     = 2048;
   localparam int DEF_MAX_ROWS     = 2048;
   localparam int DEF_FINE_RADIUS  = 1;
   localparam int DEF_COARSE_RADIUS = 5;

   localparam int CFG_W    = 12;
   localparam int CSR_IW   = 2;
   localparam int QW       = 8;

   localparam logic [CSR_IW-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_THRESHOLD    = 2'd2;

   localparam int RST_WIDTH     = 1920;
   localparam int RST_HEIGHT    = 1080;
   localparam int RST_THRESHOLD = 20;

   localparam int LUMA_SW = 18;
   localparam logic [LUMA_SW-1:0] LUMA_R_WT = 18'd299;
   localparam logic [LUMA_SW-1:0] LUMA_G_WT = 18'd587;
   localparam logic [LUMA_SW-1:0] LUMA_B_WT = 18'd114;
   localparam logic [LUMA_SW-1:0] LUMA_RND  = 18'd500;
   localparam logic [LUMA_SW-1:0] LUMA_DIV  = 18'd1000;
   // floor(2^20 / 1000); the estimate is at most one low
   localparam logic [10:0] LUMA_RCP = 11'd1048;
   localparam int LUMA_RCP_SH = 20;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_RCP,
      S_COR,
      S_NEED,
      S_CHECK,
      S_SCAN,
      S_DRAIN,
      S_FEED,
      S_DIV,
      S_OUT
   } state_type;

endpackage

[rtl/dog_box_blur_threshold_top.sv]
// Difference-of-box-means blob detector.
// req_ carries one item: tuser = opcode (pixel or flush), tdata = blue, green, red.
// rsp_ carries one result: tdata = dog value, tuser = threshold flag,
// tlast = last pixel of the frame. csr_ writes frame width, height and threshold;
// the user must write them only while idle; the block itself does not enforce it.
// A width or height write restarts the frame. Items are handled one at a time.
// A pixel item passes the luma multiply, reciprocal and correction states and then
// the window setup and check; when its result is due, the window scan reads one
// line-store entry per position of the (2*max(FINE_RADIUS,COARSE_RADIUS)+1)^2
// window (121 at the default radii), then passes the drain and feed states, the
// divider cell chain and the output register. A flush item skips the luma states.
// Results leave in raster order; the single line-store read port sets the scan length.
// Reset restores the default registers and empties the pending count; line
// store contents are undefined until written. If the receiver stalls, the
// result waits in the output register while the next request is accepted;
// the following result waits for that register to empty.
module dog_box_blur_threshold_top #(
   parameter int MAX_LINE      = dbbt_pkg::DEF_MAX_LINE,
   parameter int MAX_ROWS      = dbbt_pkg::DEF_MAX_ROWS,
   parameter int FINE_RADIUS   = dbbt_pkg::DEF_FINE_RADIUS,
   parameter int COARSE_RADIUS = dbbt_pkg::DEF_COARSE_RADIUS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // blue, green, red
   input  logic                        req_tuser,   // opcode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // dog_value
   output logic                        rsp_tuser,   // above_threshold
   output logic                        rsp_tlast,   // frame_end
   input  logic                        csr_we,
   input  logic [dbbt_pkg::CSR_IW-1:0] csr_index,
   input  logic [dbbt_pkg::CFG_W-1:0]  csr_wdata
);

   import dbbt_pkg::*;

   localparam int BR   = (FINE_RADIUS > COARSE_RADIUS) ? FINE_RADIUS : COARSE_RADIUS;
   localparam int D    = 2 * BR * MAX_LINE + 2 * BR + 1;
   localparam int AW   = $clog2(D);
   localparam int CB   = $clog2(MAX_LINE);
   localparam int RB   = $clog2(MAX_ROWS);
   localparam int WW   = $clog2(MAX_LINE + 1);
   localparam int HW   = $clog2(MAX_ROWS + 1);
   localparam int NWIN = (2 * BR + 1) * (2 * BR + 1);
   localparam int CW   = $clog2(NWIN + 1);
   localparam int SW   = $clog2(NWIN * 255 + 1);
   localparam int LB   = $clog2(BR + 1);
   localparam int DB   = LB + 1;
   localparam int RST_W = (RST_WIDTH > MAX_LINE) ? MAX_LINE : RST_WIDTH;
   localparam int RST_H = (RST_HEIGHT > MAX_ROWS) ? MAX_ROWS : RST_HEIGHT;
   localparam logic signed [DB-1:0] BR_P = DB'(BR);
   localparam logic signed [DB-1:0] BR_N = DB'(-BR);
   localparam logic signed [DB-1:0] FR_P = DB'(FINE_RADIUS);
   localparam logic signed [DB-1:0] FR_N = DB'(-FINE_RADIUS);
   localparam logic signed [DB-1:0] CR_P = DB'(COARSE_RADIUS);
   localparam logic signed [DB-1:0] CR_N = DB'(-COARSE_RADIUS);

   state_type state_ff, state_in;

   logic                 op_ff;
   logic [7:0]           blue_ff, green_ff, red_ff;
   logic [LUMA_SW-1:0]   lsum_ff;
   logic [7:0]           q0_ff;
   logic [WW-1:0]        eff_w_ff;
   logic [HW-1:0]        eff_h_ff;
   logic [7:0]           thr_ff;
   logic [CB-1:0]        out_col_ff;
   logic [RB-1:0]        out_row_ff;
   logic [AW-1:0]        pending_ff, base_ff, need_ff, addr_ff, row_ff;
   logic signed [DB-1:0] dy_ff, dx_ff;
   logic [1:0]           tag_ff;
   logic [SW-1:0]        sum_c_ff, sum_f_ff;
   logic [CW-1:0]        cnt_c_ff, cnt_f_ff;
   logic                 rsp_valid_ff, rsp_user_ff, rsp_last_ff;
   logic [7:0]           rsp_data_ff;

   // luma correction
   logic [28:0]          rcp_prod;
   logic [LUMA_SW-1:0]   luma_rem;
   logic [7:0]           luma;
   logic [AW:0]          wr_sum;
   logic [AW-1:0]        wr_addr;

   // window setup
   logic [HW-1:0]        rows_left;
   logic [WW-1:0]        cols_left;
   logic [LB-1:0]        dyl, dxl;
   logic [AW-1:0]        need_c, koff, start_c;

   // scan
   logic signed [RB+1:0] yy;
   logic signed [CB+1:0] xx;
   logic                 in_frame, in_coarse, in_fine, scan_last;
   logic [AW-1:0]        addr_next, row_next;
   logic [AW:0]          addr_inc, row_add;
   logic [7:0]           rd_data;

   // output
   logic                 out_load, frame_end_c;
   logic [7:0]           dog_c;
   logic [CB:0]          col_inc;
   logic [RB:0]          row_inc;

   // divider chain
   logic             dv_v [QW+1];
   logic [SW-1:0]    dv_rc [QW+1];
   logic [SW-1:0]    dv_rf [QW+1];
   logic [CW-1:0]    dv_dc [QW+1];
   logic [CW-1:0]    dv_df [QW+1];
   logic [QW-1:0]    dv_qc [QW+1];
   logic [QW-1:0]    dv_qf [QW+1];

   assign req_tready = (state_ff == S_IDLE);

   // luma = floor((299r + 587g + 114b + 500) / 1000)
   always_comb begin
      rcp_prod = 29'(lsum_ff) * 29'(LUMA_RCP);
      luma_rem = lsum_ff - LUMA_SW'(q0_ff) * LUMA_DIV;
      luma     = (luma_rem >= LUMA_DIV) ? q0_ff + 8'd1 : q0_ff;
      wr_sum   = (AW + 1)'(base_ff) + (AW + 1)'(pending_ff);
      wr_addr  = (wr_sum >= (AW + 1)'(D)) ? AW'(wr_sum - (AW + 1)'(D)) : AW'(wr_sum);
   end

   always_comb begin
      rows_left = eff_h_ff - HW'(1) - HW'(out_row_ff);
      cols_left = eff_w_ff - WW'(1) - WW'(out_col_ff);
      dyl = (rows_left > HW'(BR)) ? LB'(BR) : LB'(rows_left);
      dxl = (cols_left > WW'(BR)) ? LB'(BR) : LB'(cols_left);
      need_c  = AW'(dyl) * AW'(eff_w_ff) + AW'(dxl) + AW'(1);
      koff    = AW'(BR) * AW'(eff_w_ff) + AW'(BR);
      start_c = (base_ff >= koff) ? base_ff - koff : base_ff + AW'(D) - koff;
   end

   always_comb begin
      yy = $signed({2'b00, out_row_ff}) + (RB + 2)'(dy_ff);
      xx = $signed({2'b00, out_col_ff}) + (CB + 2)'(dx_ff);
      in_frame = (yy >= 0) && (yy < $signed((RB + 2)'(eff_h_ff)))
              && (xx >= 0) && (xx < $signed((CB + 2)'(eff_w_ff)));
      in_coarse = in_frame && (dy_ff >= CR_N) && (dy_ff <= CR_P)
               && (dx_ff >= CR_N) && (dx_ff <= CR_P);
      in_fine   = in_frame && (dy_ff >= FR_N) && (dy_ff <= FR_P)
               && (dx_ff >= FR_N) && (dx_ff <= FR_P);
      scan_last = (dy_ff == BR_P) && (dx_ff == BR_P);
      addr_inc  = (AW + 1)'(addr_ff) + (AW + 1)'(1);
      addr_next = (addr_inc == (AW + 1)'(D)) ? AW'(0) : AW'(addr_inc);
      row_add   = (AW + 1)'(row_ff) + (AW + 1)'(eff_w_ff);
      row_next  = (row_add >= (AW + 1)'(D)) ? AW'(row_add - (AW + 1)'(D)) : AW'(row_add);
   end

   always_comb begin
      out_load    = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
      dog_c       = (dv_qf[QW] > dv_qc[QW]) ? dv_qf[QW] - dv_qc[QW] : 8'd0;
      frame_end_c = (HW'(out_row_ff) == eff_h_ff - HW'(1))
                 && (WW'(out_col_ff) == eff_w_ff - WW'(1));
      col_inc     = (CB + 1)'(out_col_ff) + (CB + 1)'(1);
      row_inc     = (RB + 1)'(out_row_ff) + (RB + 1)'(1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == OP_FLUSH) ? S_NEED : S_MUL;
            end
         end
         S_MUL:   state_in = S_RCP;
         S_RCP:   state_in = S_COR;
         S_COR:   state_in = S_NEED;
         S_NEED:  state_in = (pending_ff == '0) ? S_IDLE : S_CHECK;
         S_CHECK: begin
            state_in = (op_ff == OP_FLUSH || pending_ff >= need_ff) ? S_SCAN : S_IDLE;
         end
         S_SCAN:  state_in = scan_last ? S_DRAIN : S_SCAN;
         S_DRAIN: state_in = S_FEED;
         S_FEED:  state_in = S_DIV;
         S_DIV:   state_in = dv_v[QW] ? S_OUT : S_DIV;
         S_OUT:   state_in = out_load ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration and frame position
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff   <= WW'(RST_W);
         eff_h_ff   <= HW'(RST_H);
         thr_ff     <= 8'(RST_THRESHOLD);
         out_col_ff <= '0;
         out_row_ff <= '0;
         pending_ff <= '0;
         base_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH: begin
                  if (csr_wdata == '0) begin
                     eff_w_ff <= WW'(1);
                  end else if (32'(csr_wdata) > 32'(MAX_LINE)) begin
                     eff_w_ff <= WW'(MAX_LINE);
                  end else begin
                     eff_w_ff <= WW'(csr_wdata);
                  end
               end
               CSR_FRAME_HEIGHT: begin
                  if (csr_wdata == '0) begin
                     eff_h_ff <= HW'(1);
                  end else if (32'(csr_wdata) > 32'(MAX_ROWS)) begin
                     eff_h_ff <= HW'(MAX_ROWS);
                  end else begin
                     eff_h_ff <= HW'(csr_wdata);
                  end
               end
               CSR_THRESHOLD: thr_ff <= csr_wdata[7:0];
               default: ;
            endcase
            if (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT) begin
               out_col_ff <= '0;
               out_row_ff <= '0;
               pending_ff <= '0;
               base_ff    <= '0;
            end
         end else if (state_ff == S_COR) begin
            pending_ff <= pending_ff + AW'(1);
         end else if (out_load) begin
            pending_ff <= pending_ff - AW'(1);
            base_ff    <= (base_ff == AW'(D - 1)) ? AW'(0) : base_ff + AW'(1);
            if (col_inc >= (CB + 1)'(eff_w_ff)) begin
               out_col_ff <= '0;
               out_row_ff <= (row_inc >= (RB + 1)'(eff_h_ff)) ? RB'(0) : RB'(row_inc);
            end else begin
               out_col_ff <= CB'(col_inc);
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff    <= req_tuser;
         blue_ff  <= req_tdata[7:0];
         green_ff <= req_tdata[15:8];
         red_ff   <= req_tdata[23:16];
      end
      if (state_ff == S_MUL) begin
         lsum_ff <= LUMA_SW'(red_ff) * LUMA_R_WT + LUMA_SW'(green_ff) * LUMA_G_WT
                  + LUMA_SW'(blue_ff) * LUMA_B_WT + LUMA_RND;
      end
      if (state_ff == S_RCP) begin
         q0_ff <= 8'(rcp_prod >> LUMA_RCP_SH);
      end
      if (state_ff == S_NEED) begin
         need_ff  <= need_c;
         addr_ff  <= start_c;
         row_ff   <= start_c;
         dy_ff    <= BR_N;
         dx_ff    <= BR_N;
         sum_c_ff <= '0;
         sum_f_ff <= '0;
         cnt_c_ff <= '0;
         cnt_f_ff <= '0;
      end else begin
         if (state_ff == S_SCAN) begin
            if (dx_ff == BR_P) begin
               dx_ff   <= BR_N;
               dy_ff   <= dy_ff + DB'(1);
               row_ff  <= row_next;
               addr_ff <= row_next;
            end else begin
               dx_ff   <= dx_ff + DB'(1);
               addr_ff <= addr_next;
            end
         end
         if (tag_ff[0]) begin
            sum_c_ff <= sum_c_ff + SW'(rd_data);
            cnt_c_ff <= cnt_c_ff + CW'(1);
         end
         if (tag_ff[1]) begin
            sum_f_ff <= sum_f_ff + SW'(rd_data);
            cnt_f_ff <= cnt_f_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= 2'b00;
      end else begin
         tag_ff <= (state_ff == S_SCAN) ? {in_fine, in_coarse} : 2'b00;
      end
   end

   dbbt_ram #(
      .WIDTH (8),
      .DEPTH (D)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (state_ff == S_COR),
      .wr_addr (wr_addr),
      .wr_data (luma),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign dv_v[0]  = (state_ff == S_FEED);
   assign dv_rc[0] = sum_c_ff;
   assign dv_rf[0] = sum_f_ff;
   assign dv_dc[0] = cnt_c_ff;
   assign dv_df[0] = cnt_f_ff;
   assign dv_qc[0] = '0;
   assign dv_qf[0] = '0;

   for (genvar i = 0; i < QW; i++) begin : g_div
      dbbt_div_cell #(
         .SW    (SW),
         .CW    (CW),
         .QBITS (QW),
         .SHIFT (QW - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_v[i]),
         .in_rem_c  (dv_rc[i]),
         .in_rem_f  (dv_rf[i]),
         .in_div_c  (dv_dc[i]),
         .in_div_f  (dv_df[i]),
         .in_q_c    (dv_qc[i]),
         .in_q_f    (dv_qf[i]),
         .out_valid (dv_v[i+1]),
         .out_rem_c (dv_rc[i+1]),
         .out_rem_f (dv_rf[i+1]),
         .out_div_c (dv_dc[i+1]),
         .out_div_f (dv_df[i+1]),
         .out_q_c   (dv_qc[i+1]),
         .out_q_f   (dv_qf[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= dog_c;
         rsp_user_ff <= (dog_c >= thr_ff);
         rsp_last_ff <= frame_end_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/dbbt_ram.sv]
module dbbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dbbt_div_cell.sv]
// One quotient bit of the two box-mean divisions (coarse and fine lanes).
module dbbt_div_cell #(
   parameter int SW    = 15,
   parameter int CW    = 7,
   parameter int QBITS = 8,
   parameter int SHIFT = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [SW-1:0]    in_rem_c,
   input  logic [SW-1:0]    in_rem_f,
   input  logic [CW-1:0]    in_div_c,
   input  logic [CW-1:0]    in_div_f,
   input  logic [QBITS-1:0] in_q_c,
   input  logic [QBITS-1:0] in_q_f,
   output logic             out_valid,
   output logic [SW-1:0]    out_rem_c,
   output logic [SW-1:0]    out_rem_f,
   output logic [CW-1:0]    out_div_c,
   output logic [CW-1:0]    out_div_f,
   output logic [QBITS-1:0] out_q_c,
   output logic [QBITS-1:0] out_q_f
);

   localparam int XW = SW + QBITS + CW;

   logic             valid_ff;
   logic [SW-1:0]    rem_c_ff, rem_f_ff, rem_c_in, rem_f_in;
   logic [CW-1:0]    div_c_ff, div_f_ff;
   logic [QBITS-1:0] q_c_ff, q_f_ff, q_c_in, q_f_in;
   logic [XW-1:0]    dsh_c, dsh_f;
   logic             ge_c, ge_f;

   always_comb begin
      dsh_c = XW'(in_div_c) << SHIFT;
      dsh_f = XW'(in_div_f) << SHIFT;
      ge_c  = XW'(in_rem_c) >= dsh_c;
      ge_f  = XW'(in_rem_f) >= dsh_f;
      rem_c_in = ge_c ? SW'(XW'(in_rem_c) - dsh_c) : in_rem_c;
      rem_f_in = ge_f ? SW'(XW'(in_rem_f) - dsh_f) : in_rem_f;
      q_c_in = in_q_c;
      q_f_in = in_q_f;
      q_c_in[SHIFT] = ge_c;
      q_f_in[SHIFT] = ge_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_c_ff <= rem_c_in;
      rem_f_ff <= rem_f_in;
      div_c_ff <= in_div_c;
      div_f_ff <= in_div_f;
      q_c_ff   <= q_c_in;
      q_f_ff   <= q_f_in;
   end

   assign out_valid = valid_ff;
   assign out_rem_c = rem_c_ff;
   assign out_rem_f = rem_f_ff;
   assign out_div_c = div_c_ff;
   assign out_div_f = div_f_ff;
   assign out_q_c   = q_c_ff;
   assign out_q_f   = q_f_ff;

endmodule

[rtl/dbbt_checker.sv]
`include "dog_box_blur_threshold_top_assert.svh"

module dbbt_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   // a stalled result stays offered
   `DBBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // one request at a time: no accept on the cycle after an accept
   `DBBT_ASSERT_NEXT(a_one_request, clock, reset, req_tvalid && req_tready, !req_tready)

   // reset empties the output register and reopens the request side
   `DBBT_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind dog_box_blur_threshold_top dbbt_checker u_dbbt_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import dbbt_pkg::*;

   localparam int BIG_R = (DEF_COARSE_RADIUS > DEF_FINE_RADIUS) ?
                          DEF_COARSE_RADIUS : DEF_FINE_RADIUS;
   localparam int RING = 2 * BIG_R * DEF_MAX_LINE + 2 * BIG_R + 1;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [7:0] dog;
      logic       flag;
      logic       last;
   } blob_res_type;

   typedef enum int {ROW_PREDICT, ROW_RESULT, ROW_NONE} row_kind_type;

   typedef struct {
      logic         op;
      logic [7:0]   b;
      logic [7:0]   g;
      logic [7:0]   r;
      row_kind_type kind;
      blob_res_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // blue, green, red
   logic        req_tuser = 1'b0;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // dog_value
   logic        rsp_tuser;         // above_threshold
   logic        rsp_tlast;         // frame_end
   logic        csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CFG_W-1:0]  csr_wdata = '0;

   dog_box_blur_threshold_top u_top (.*);

   always #6 clock = ~clock;

   // predictor state
   byte unsigned luma_mem [RING];
   bit           luma_known [RING];
   int unsigned  cfg_w = RST_WIDTH, cfg_h = RST_HEIGHT, cfg_thr = RST_THRESHOLD;
   int           pos_r, pos_c, npend, ring_base;

   blob_res_type blob_q[$];
   int        err_count, blob_count, req_count, flush_count;
   int        burst_left;
   bit        long_hold_go;

   function automatic int eff_w();
      if (cfg_w == 0) return 1;
      if (cfg_w > DEF_MAX_LINE) return DEF_MAX_LINE;
      return cfg_w;
   endfunction

   function automatic int eff_h();
      if (cfg_h == 0) return 1;
      if (cfg_h > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return cfg_h;
   endfunction

   // clipped window of radius rad around the next output pixel
   function automatic void clip_box(input int rad, output int y0, y1, x0, x1);
      y0 = (pos_r - rad < 0) ? 0 : pos_r - rad;
      y1 = (pos_r + rad > eff_h() - 1) ? eff_h() - 1 : pos_r + rad;
      x0 = (pos_c - rad < 0) ? 0 : pos_c - rad;
      x1 = (pos_c + rad > eff_w() - 1) ? eff_w() - 1 : pos_c + rad;
   endfunction

   function automatic int win_addr(int y, int x);
      return (ring_base + RING + (y - pos_r) * eff_w() + (x - pos_c)) % RING;
   endfunction

   function automatic int unsigned box_avg(int rad);
      int y0, y1, x0, x1;
      int unsigned sum;
      sum = 0;
      clip_box(rad, y0, y1, x0, x1);
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            sum += luma_mem[win_addr(y, x)];
      return sum / ((y1 - y0 + 1) * (x1 - x0 + 1));
   endfunction

   // a flush must not pull a line-store entry that was never written
   function automatic bit flush_safe();
      int y0, y1, x0, x1;
      if (npend == 0) return 1;
      clip_box(BIG_R, y0, y1, x0, x1);
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            if (!luma_known[win_addr(y, x)]) return 0;
      return 1;
   endfunction

   function automatic void restart_frame();
      pos_r = 0;
      pos_c = 0;
      npend = 0;
      ring_base = 0;
   endfunction

   function automatic bit predict_blob(input logic op, input logic [7:0] b, g, r,
                                       output blob_res_type res);
      int w, h, ly, lx, need, addr;
      int unsigned fine, coarse, dog;
      w = eff_w();
      h = eff_h();
      res = '0;
      if (op == OP_PIXEL) begin
         addr = (ring_base + npend) % RING;
         luma_mem[addr] = 8'((r * 299 + g * 587 + b * 114 + 500) / 1000);
         luma_known[addr] = 1;
         npend++;
      end
      if (npend == 0) return 0;
      ly = (pos_r + BIG_R > h - 1) ? h - 1 : pos_r + BIG_R;
      lx = (pos_c + BIG_R > w - 1) ? w - 1 : pos_c + BIG_R;
      need = (ly - pos_r) * w + (lx - pos_c) + 1;
      if (op != OP_FLUSH && npend < need) return 0;
      fine = box_avg(DEF_FINE_RADIUS);
      coarse = box_avg(DEF_COARSE_RADIUS);
      dog = (fine > coarse) ? fine - coarse : 0;
      if (dog > 255) dog = 255;
      res.dog = 8'(dog);
      res.flag = (dog >= cfg_thr);
      res.last = (pos_r == h - 1 && pos_c == w - 1);
      ring_base = (ring_base + 1) % RING;
      npend--;
      pos_c++;
      if (pos_c >= w) begin
         pos_c = 0;
         pos_r++;
         if (pos_r >= h) pos_r = 0;
      end
      return 1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      err_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      blob_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         blob_count++;
         if (blob_q.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            want = blob_q.pop_front();
            if (rsp_tdata !== want.dog)
               report_mismatch($sformatf("dog_value got %0d want %0d", rsp_tdata, want.dog));
            if (rsp_tuser !== want.flag)
               report_mismatch($sformatf("above_threshold got %b want %b",
                                         rsp_tuser, want.flag));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("frame_end got %b want %b", rsp_tlast, want.last));
         end
      end
   end

   // receiver: rotates through four stall patterns, plus one long hold-off
   int rx_cycle, hold_cnt;
   always @(posedge clock) begin
      rx_cycle++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_go && hold_cnt < HOLD_CYCLES) begin
         hold_cnt++;
         rsp_tready <= 1'b0;
      end else begin
         case ((rx_cycle / 400) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ((rx_cycle % 37) > 20);
         endcase
      end
   end

   task automatic send_request(input logic op, input logic [7:0] b, g, r,
                               input row_kind_type kind, input blob_res_type typed);
      blob_res_type res;
      bit           hit;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {r, g, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_count++;
      if (op == OP_FLUSH) flush_count++;
      hit = predict_blob(op, b, g, r, res);
      if (kind == ROW_RESULT) blob_q.push_back(typed);
      else if (kind == ROW_PREDICT && hit) blob_q.push_back(res);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic send_random(input logic op);
      logic [7:0] b, g, r;
      if (op == OP_FLUSH && !flush_safe()) op = OP_PIXEL;
      case ($urandom_range(0, 9))
         0: {b, g, r} = '0;
         1: {b, g, r} = '1;
         default: {b, g, r} = 24'($urandom);
      endcase
      send_request(op, b, g, r, ROW_PREDICT, '0);
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (blob_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IW-1:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH: begin
            cfg_w = val & 12'hfff;
            restart_frame();
         end
         CSR_FRAME_HEIGHT: begin
            cfg_h = val & 12'hfff;
            restart_frame();
         end
         CSR_THRESHOLD: cfg_thr = val & 8'hff;
         default: ;
      endcase
   endtask

   task automatic set_frame(input int unsigned w, h, thr);
      drain_all();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_THRESHOLD, thr);
   endtask

   task automatic run_table(input stim_row_type rows[]);
      foreach (rows[i])
         send_request(rows[i].op, rows[i].b, rows[i].g, rows[i].r, rows[i].kind,
                      rows[i].res);
   endtask

   // 1x1 frame: both means equal the pixel, so every pixel gives dog 0, last set
   localparam blob_res_type ONE_PX = '{dog: 8'd0, flag: 1'b1, last: 1'b1};
   stim_row_type tab_single[] = '{
      '{OP_PIXEL, 8'd0,   8'd0,   8'd0,   ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd255, 8'd255, 8'd255, ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd255, 8'd0,   8'd0,   ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd0,   8'd255, 8'd0,   ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd0,   8'd0,   8'd255, ROW_RESULT, ONE_PX},
      '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   ROW_NONE,   '0},
      '{OP_PIXEL, 8'h55,  8'hAA,  8'h55,  ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'hAA,  8'h55,  8'hAA,  ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd1,   8'd128, 8'd254, ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd128, 8'd1,   8'd127, ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd17,  8'd200, 8'd99,  ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd240, 8'd15,  8'd60,  ROW_RESULT, ONE_PX},
      '{OP_PIXEL, 8'd7,   8'd77,  8'd177, ROW_RESULT, ONE_PX}
   };
   // 4x3 frame: early flushes, then more pixels of the same frame without a flush
   stim_row_type tab_small[] = '{
      '{OP_PIXEL, 8'd255, 8'd255, 8'd255, ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd0,   8'd0,   8'd0,   ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd255, 8'd255, 8'd255, ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd0,   8'd0,   8'd0,   ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd255, 8'd0,   8'd255, ROW_PREDICT, '0},
      '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   ROW_PREDICT, '0},
      '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd90,  8'd30,  8'd200, ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd255, 8'd255, 8'd0,   ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd3,   8'd250, 8'd9,   ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd128, 8'd128, 8'd128, ROW_PREDICT, '0},
      '{OP_PIXEL, 8'd200, 8'd10,  8'd40,  ROW_PREDICT, '0}
   };

   initial begin
      restart_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      set_frame(1, 1, 0);
      run_table(tab_single);
      set_frame(4, 3, 255);
      run_table(tab_small);
      for (int i = 0; i < 14; i++) send_random(OP_FLUSH);

      // out-of-range and extreme dimensions
      set_frame(0, 4095, 1);
      for (int i = 0; i < 20; i++) send_random(OP_PIXEL);
      set_frame(4095, 0, 128);
      for (int i = 0; i < 20; i++) send_random(OP_PIXEL);
      set_frame(2048, 1, 5);
      for (int i = 0; i < 20; i++) send_random(OP_PIXEL);
      for (int i = 0; i < 8; i++) send_random(OP_FLUSH);

      // random frames, mostly well-formed pixel streams
      while (req_count < 400) begin
         int n, frame_px;
         set_frame($urandom_range(1, 12), $urandom_range(1, 10),
                   ($urandom_range(0, 5) == 0) ? 255 * $urandom_range(0, 1)
                                               : $urandom_range(0, 40));
         n = $urandom_range(20, 60);
         frame_px = 0;
         for (int i = 0; i < n; i++) begin
            if (req_count > 250 && !long_hold_go) long_hold_go = 1;
            if ($urandom_range(0, 11) == 0) begin
               send_random(OP_FLUSH);
            end else begin
               send_random(OP_PIXEL);
               frame_px++;
               if (frame_px == eff_w() * eff_h()) begin
                  frame_px = 0;
                  if ($urandom_range(0, 1))
                     while (npend > 0) send_random(OP_FLUSH);
               end
            end
         end
      end

      drain_all();
      $display("covered %0d requests (%0d flushes), %0d results checked,",
               req_count, flush_count, blob_count);
      $display("frames from 1x1 up to 2048 wide, clamped sizes and threshold extremes");
      if (err_count == 0)
         $display("** dog_box_blur_threshold_top: PASSED **");
      else
         $display("** dog_box_blur_threshold_top: FAILED **");
      $finish;
   end

   initial begin
      #48_000_000;
      $display("timeout");
      $display("** dog_box_blur_threshold_top: FAILED **");
      $finish;
   end

endmodule
